// ----- rtl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Widths, command and error codes, and sequencer types that the unit uses.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OPERAND_BITS = 16;
  localparam int MAG_W        = OPERAND_BITS;
  localparam int RED_W        = 2 * OPERAND_BITS;
  localparam int CNT_W        = $clog2(RED_W);
  localparam int NUM_W        = 33;
  localparam int DEN_W        = 31;
  localparam int IN_W         = 3 + 4 * 16;
  localparam int IN_BYTES_W   = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W        = NUM_W + DEN_W + 1 + 2;
  localparam int OUT_BYTES_W  = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_SUB     = 3'd1,
    CMD_MUL     = 3'd2,
    CMD_DIV     = 3'd3,
    CMD_COMPARE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_DEN_ZERO = 2'd1,
    ERR_DIV_ZERO = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_MUL,
    S_COMB,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_R
  } phase_t;

  typedef struct packed {
    logic             neg;
    logic [RED_W-1:0] mag;
  } signed_mag_t;

endpackage

// ----- rtl/rational_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies, divides or compares two fractions and returns
// the result reduced to lowest terms, with a less-than flag and an error code.
// ----------------------------------------------------------------------------
// Sequence: add, subtract, multiply and divide run three binary gcds (one compare/subtract
// or shift per cycle), six 32-bit restoring divisions, four products and the combine step.
// Compare, the unused command codes and division by zero skip the result gcd and its two
// divisions. An operand with a zero denominator goes from the check straight to output.
// Throughput: one item at a time; s_tready is high only while idle.
// Reset: rst (synchronous, active high) returns the sequencer to idle and
// drops m_tvalid; datapath registers are not reset.
module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // command[2:0], a_num[18:3], a_den[34:19], b_num[50:35], b_den[66:51], zero pad
  input  logic [IN_BYTES_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // result_num[32:0], result_den[63:33], a_less_than_b[64], error_code[66:65],
  // zero pad
  output logic [OUT_BYTES_W-1:0] m_tdata
);

  state_t state, state_next;
  phase_t phase;
  cmd_t   cmd;

  // Split operand magnitudes and signs, captured at input acceptance.
  logic [MAG_W-1:0] an, ad, bn, bd;
  logic             an_s, ad_s, bn_s, bd_s;

  // Normalized operands.
  logic [MAG_W-1:0] a_n, a_d, b_n, b_d;
  logic             a_neg, b_neg;

  // Products from the shared multiplier.
  logic [RED_W-1:0] p, q, n2, dp;
  logic [1:0]       mul_idx;

  // Reduction operand and gcd working registers.
  logic             red_neg;
  logic [RED_W-1:0] red_n, red_d;
  logic [RED_W-1:0] u, v, g;
  logic [CNT_W-1:0] k;

  // Restoring divider registers.
  logic [RED_W-1:0] rem, dvd, quo, qn;
  logic [CNT_W-1:0] bit_cnt;

  // Result registers.
  logic [NUM_W-1:0] out_num;
  logic [DEN_W-1:0] out_den;
  logic             out_less;
  err_t             out_err;

  // Shared subtractor: gcd compare/subtract and divider trial subtract.
  logic [RED_W:0]   alu_x, alu_y, alu_d;
  logic             borrow;

  logic [RED_W-1:0] quo_next;
  logic             div_last;

  logic [MAG_W-1:0] mul_x, mul_y;
  logic [RED_W-1:0] prod;

  signed_mag_t      diff_r, sum_r;
  logic             diff_yneg;

  // Sign-magnitude conversion of the wide quotient for the output field.
  logic [RED_W+NUM_W-1:0] num_ext, num_neg;
  logic [RED_W+DEN_W-1:0] den_ext;

  function automatic logic [MAG_W-1:0] mag_of(input logic [15:0] raw);
    logic [MAG_W-1:0] v_l;
    v_l = raw[MAG_W-1:0];
    return v_l[MAG_W-1] ? (~v_l + 1'b1) : v_l;
  endfunction

  // Signed sum of two nonnegative products x and y with signs xn and yn.
  function automatic signed_mag_t combine(input logic [RED_W-1:0] x,
                                          input logic [RED_W-1:0] y,
                                          input logic xn, input logic yn);
    signed_mag_t r;
    if (xn == yn) begin
      r.mag = x + y;
      r.neg = xn;
    end else if (x >= y) begin
      r.mag = x - y;
      r.neg = xn;
    end else begin
      r.mag = y - x;
      r.neg = yn;
    end
    r.neg = r.neg && (r.mag != '0);
    return r;
  endfunction

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);

  always_comb begin
    m_tdata = '0;
    m_tdata[NUM_W-1:0]              = out_num;
    m_tdata[NUM_W+DEN_W-1:NUM_W]    = out_den;
    m_tdata[NUM_W+DEN_W]            = out_less;
    m_tdata[NUM_W+DEN_W+2:NUM_W+DEN_W+1] = out_err;
  end

  always_comb begin
    if (state == S_GCD) begin
      alu_x = {1'b0, u};
      alu_y = {1'b0, v};
    end else begin
      alu_x = {rem, dvd[RED_W-1]};
      alu_y = {1'b0, g};
    end
    alu_d  = alu_x - alu_y;
    borrow = alu_d[RED_W];
  end

  assign quo_next = {quo[RED_W-2:0], ~borrow};
  assign div_last = (bit_cnt == CNT_W'(RED_W - 1));

  always_comb begin
    case (mul_idx)
      2'd0: begin mul_x = a_n; mul_y = b_d; end
      2'd1: begin mul_x = b_n; mul_y = a_d; end
      2'd2: begin mul_x = a_n; mul_y = b_n; end
      default: begin mul_x = a_d; mul_y = b_d; end
    endcase
    prod = mul_x * mul_y;
  end

  // Difference uses -b; its sign is set only for a nonzero b.
  assign diff_yneg = (b_n != '0) && !b_neg;
  assign diff_r    = combine(p, q, a_neg, diff_yneg);
  assign sum_r     = combine(p, q, a_neg, b_neg);

  assign num_ext = {{NUM_W{1'b0}}, qn};
  assign num_neg = red_neg ? (~num_ext + 1'b1) : num_ext;
  assign den_ext = {{DEN_W{1'b0}}, quo_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (s_tvalid) state_next = S_CHECK;
      S_CHECK: state_next = (ad == '0 || bd == '0) ? S_OUT : S_GCD;
      S_GCD:   if (u == '0) state_next = S_DIVN;
      S_DIVN:  if (div_last) state_next = S_DIVD;
      S_DIVD: begin
        if (div_last) begin
          state_next = (phase == PH_A) ? S_GCD :
                       (phase == PH_B) ? S_MUL : S_OUT;
        end
      end
      S_MUL:   if (mul_idx == 2'd3) state_next = S_COMB;
      S_COMB: begin
        case (cmd)
          CMD_ADD, CMD_SUB, CMD_MUL: state_next = S_GCD;
          CMD_DIV: state_next = (b_n == '0) ? S_OUT : S_GCD;
          default: state_next = S_OUT;
        endcase
      end
      S_OUT:   if (m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd  <= cmd_t'(s_tdata[2:0]);
        an   <= mag_of(s_tdata[18:3]);
        ad   <= mag_of(s_tdata[34:19]);
        bn   <= mag_of(s_tdata[50:35]);
        bd   <= mag_of(s_tdata[66:51]);
        an_s <= s_tdata[3 + MAG_W - 1];
        ad_s <= s_tdata[19 + MAG_W - 1];
        bn_s <= s_tdata[35 + MAG_W - 1];
        bd_s <= s_tdata[51 + MAG_W - 1];
      end
      S_CHECK: begin
        out_num  <= '0;
        out_den  <= DEN_W'(1);
        out_less <= 1'b0;
        out_err  <= ERR_DEN_ZERO;
        phase    <= PH_A;
        red_neg  <= an_s ^ ad_s;
        red_n    <= RED_W'(an);
        red_d    <= RED_W'(ad);
        u        <= RED_W'(an);
        v        <= RED_W'(ad);
        k        <= '0;
      end
      S_GCD: begin
        if (u == '0) begin
          g       <= v << k;
          rem     <= '0;
          dvd     <= red_n;
          bit_cnt <= '0;
        end else if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + 1'b1;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (borrow) begin
          u <= v;
          v <= u;
        end else begin
          u <= alu_d[RED_W-1:0];
        end
      end
      S_DIVN, S_DIVD: begin
        quo <= quo_next;
        if (div_last) begin
          rem     <= '0;
          bit_cnt <= '0;
          if (state == S_DIVN) begin
            qn  <= quo_next;
            dvd <= red_d;
          end else begin
            case (phase)
              PH_A: begin
                a_n     <= qn[MAG_W-1:0];
                a_d     <= quo_next[MAG_W-1:0];
                a_neg   <= red_neg && (qn != '0);
                phase   <= PH_B;
                red_neg <= bn_s ^ bd_s;
                red_n   <= RED_W'(bn);
                red_d   <= RED_W'(bd);
                u       <= RED_W'(bn);
                v       <= RED_W'(bd);
                k       <= '0;
              end
              PH_B: begin
                b_n     <= qn[MAG_W-1:0];
                b_d     <= quo_next[MAG_W-1:0];
                b_neg   <= red_neg && (qn != '0);
                mul_idx <= 2'd0;
              end
              default: begin
                out_num <= num_neg[NUM_W-1:0];
                out_den <= den_ext[DEN_W-1:0];
              end
            endcase
          end
        end else begin
          rem     <= borrow ? alu_x[RED_W-1:0] : alu_d[RED_W-1:0];
          dvd     <= dvd << 1;
          bit_cnt <= bit_cnt + 1'b1;
        end
      end
      S_MUL: begin
        case (mul_idx)
          2'd0:    p  <= prod;
          2'd1:    q  <= prod;
          2'd2:    n2 <= prod;
          default: dp <= prod;
        endcase
        mul_idx <= mul_idx + 1'b1;
      end
      S_COMB: begin
        out_less <= diff_r.neg;
        // Division by a zero b is the only error left at this point.
        out_err  <= (cmd == CMD_DIV && b_n == '0) ? ERR_DIV_ZERO : ERR_OK;
        out_num  <= '0;
        out_den  <= DEN_W'(1);
        phase    <= PH_R;
        k        <= '0;
        case (cmd)
          CMD_ADD: begin
            red_neg <= sum_r.neg;
            red_n   <= sum_r.mag;
            red_d   <= dp;
            u       <= sum_r.mag;
            v       <= dp;
          end
          CMD_SUB: begin
            red_neg <= diff_r.neg;
            red_n   <= diff_r.mag;
            red_d   <= dp;
            u       <= diff_r.mag;
            v       <= dp;
          end
          CMD_MUL: begin
            red_neg <= a_neg ^ b_neg;
            red_n   <= n2;
            red_d   <= dp;
            u       <= n2;
            v       <= dp;
          end
          CMD_DIV: begin
            red_neg <= a_neg ^ b_neg;
            red_n   <= p;
            red_d   <= q;
            u       <= p;
            v       <= q;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Input and output sides are never open at the same time.
  assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input ready while a result is pending");

  // An accepted item always leaves the idle state.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("still ready after accepting an item");

  // Error results carry the fraction zero over one.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_err != ERR_OK) |-> (out_num == '0 && out_den == DEN_W'(1)))
    else $error("error result with nonzero fraction");

  // The gcd loop never holds a zero denominator-side value.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_GCD) |-> (v != '0))
    else $error("gcd operand collapsed to zero");

endmodule

// ----- bench/rational_arithmetic_unit_checker.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Watches both stream channels, computes the reduced fraction that each
// accepted item should give, and compares every returned item against it.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_checker
  import rau_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_BYTES_W-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_BYTES_W-1:0] m_tdata,
  output int                     fail_count,
  output int                     pending_count,
  output int                     result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             lt;
    err_t             err;
  } fraction_result_t;

  typedef struct {
    bit       neg;
    bit [63:0] num;
    bit [63:0] den;
  } fraction_t;

  fraction_result_t expected_results[$];

  function automatic bit [63:0] gcd64(bit [63:0] x, bit [63:0] y);
    bit [63:0] t;
    while (x != 0) begin
      t = y % x;
      y = x;
      x = t;
    end
    return y;
  endfunction

  function automatic fraction_t reduce(bit neg, bit [63:0] nmag, bit [63:0] dmag);
    fraction_t f;
    bit [63:0] g;
    g = gcd64(nmag, dmag);
    f.num = nmag / g;
    f.den = dmag / g;
    f.neg = (f.num != 0) && neg;
    return f;
  endfunction

  function automatic fraction_t sum(fraction_t x, fraction_t y);
    bit [63:0] p, q, mag;
    bit neg;
    p = x.num * y.den;
    q = y.num * x.den;
    if (x.neg == y.neg) begin
      mag = p + q;
      neg = x.neg;
    end else if (p >= q) begin
      mag = p - q;
      neg = x.neg;
    end else begin
      mag = q - p;
      neg = y.neg;
    end
    return reduce(neg, mag, x.den * y.den);
  endfunction

  function automatic bit [63:0] magnitude(logic [15:0] v);
    logic signed [63:0] s;
    s = $signed(v);
    return (s < 0) ? -s : s;
  endfunction

  function automatic fraction_result_t predict(logic [IN_BYTES_W-1:0] d);
    fraction_result_t r;
    fraction_t a, b, nb, diff, o;
    logic [2:0]  cmd;
    logic [15:0] an, ad, bn, bd;
    bit have;
    cmd = d[2:0];
    an = d[18:3];
    ad = d[34:19];
    bn = d[50:35];
    bd = d[66:51];
    r.num = '0;
    r.den = DEN_W'(1);
    r.lt = 1'b0;
    r.err = ERR_OK;
    have = 0;
    if (ad == 0 || bd == 0) begin
      r.err = ERR_DEN_ZERO;
      return r;
    end
    a = reduce(an[15] ^ ad[15], magnitude(an), magnitude(ad));
    b = reduce(bn[15] ^ bd[15], magnitude(bn), magnitude(bd));
    nb = b;
    nb.neg = (b.num != 0) && !b.neg;
    diff = sum(a, nb);
    o = diff;
    case (cmd)
      CMD_ADD: begin
        o = sum(a, b);
        have = 1;
      end
      CMD_SUB: have = 1;
      CMD_MUL: begin
        o = reduce(a.neg != b.neg, a.num * b.num, a.den * b.den);
        have = 1;
      end
      CMD_DIV: begin
        if (b.num == 0) r.err = ERR_DIV_ZERO;
        else begin
          o = reduce(a.neg != b.neg, a.num * b.den, a.den * b.num);
          have = 1;
        end
      end
      default: ;
    endcase
    if (have) begin
      r.num = NUM_W'(o.neg ? (64'd0 - o.num) : o.num);
      r.den = DEN_W'(o.den);
    end
    r.lt = diff.neg;
    return r;
  endfunction

  always @(posedge clk) begin
    fraction_result_t got, want;
    if (rst) begin
      expected_results.delete();
      fail_count <= 0;
      result_count <= 0;
      pending_count <= 0;
    end else begin
      if (s_tvalid && s_tready) expected_results.push_back(predict(s_tdata));
      if (m_tvalid && m_tready) begin
        got.num = m_tdata[32:0];
        got.den = m_tdata[63:33];
        got.lt = m_tdata[64];
        got.err = err_t'(m_tdata[66:65]);
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $error("unexpected result item %h", m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got != want) begin
            fail_count <= fail_count + 1;
            if (got.num != want.num)
              $error("result_num expected %0d got %0d", $signed(want.num), $signed(got.num));
            if (got.den != want.den)
              $error("result_den expected %0d got %0d", want.den, got.den);
            if (got.lt != want.lt)
              $error("a_less_than_b expected %0d got %0d", want.lt, got.lt);
            if (got.err != want.err)
              $error("error_code expected %0d got %0d", want.err, got.err);
          end
        end
      end
      pending_count <= expected_results.size();
    end
  end

endmodule

// ----- bench/rational_arithmetic_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives directed and random fraction pairs with random stalls on both sides;
// a separate checker predicts each reduced result and counts mismatches.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
  import rau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1530;
  localparam int STALL_LIMIT  = 20000;

  logic                   clk = 0;
  logic                   rst = 1;
  logic                   s_tvalid = 0;
  logic                   s_tready;
  logic [IN_BYTES_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 0;
  logic [OUT_BYTES_W-1:0] m_tdata;
  int fail_count, pending_count, result_count;
  int idle_cycles = 0;
  bit quiet = 0;  // no idling on either side near the end
  int sent = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  rational_arithmetic_unit uut (.*);

  rational_arithmetic_unit_checker checker_i (.*);

  // Receiver: random bursts of stall and of readiness.
  initial begin
    int n;
    forever begin
      n = $urandom_range(1, 16);
      m_tready <= 1;
      repeat (n) @(posedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        m_tready <= 0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Watchdog: counts cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("rational_arithmetic_unit_tb failed");
      $finish;
    end
  end

  function automatic logic [15:0] rand_value(bit wide);
    // Mostly small values so gcds actually reduce; sometimes full range.
    if (wide || $urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 40)) - 20);
  endfunction

  task automatic send(logic [2:0] cmd, logic [15:0] an, logic [15:0] ad,
                      logic [15:0] bn, logic [15:0] bd);
    s_tdata <= IN_BYTES_W'({bd, bn, ad, an, cmd});
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    // Optional idle burst after the item; otherwise valid stays high.
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic send_random();
    logic [15:0] bd;
    bd = rand_value($urandom_range(0, 1));
    if (bd == 0 && $urandom_range(0, 7) != 0) bd = 1;
    send(3'($urandom_range(0, 7)), rand_value(0), rand_value(0), rand_value(0), bd);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: every command, field extremes, zero denominators,
    // division by zero, negative denominators and zero numerators.
    send(CMD_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
    send(CMD_SUB, 16'd1, 16'd2, 16'd3, 16'd4);
    send(CMD_MUL, -16'sd6, 16'd4, 16'd2, -16'sd3);
    send(CMD_DIV, 16'd3, 16'd5, -16'sd9, 16'd10);
    send(CMD_COMPARE, 16'd1, 16'd3, 16'd1, 16'd2);
    send(3'd5, 16'd7, 16'd1, 16'd2, 16'd1);
    send(3'd6, -16'sd1, 16'd1, 16'd2, 16'd1);
    send(3'd7, 16'd0, 16'd1, 16'd0, 16'd1);
    send(CMD_ADD, 16'd1, 16'd0, 16'd1, 16'd1);
    send(CMD_DIV, 16'd1, 16'd1, 16'd1, 16'd0);
    send(CMD_DIV, 16'd5, 16'd7, 16'd0, -16'sd3);
    send(CMD_ADD, 16'h8000, 16'h8000, 16'h8000, 16'd1);
    send(CMD_SUB, 16'h8000, 16'd1, 16'h7fff, 16'd1);
    send(CMD_MUL, 16'h8000, 16'd1, 16'h8000, 16'd1);
    send(CMD_DIV, 16'h8000, 16'h7fff, 16'd1, 16'h8000);
    send(CMD_ADD, 16'h7fff, 16'h7ffe, 16'h7ffd, 16'h7ffc);
    send(CMD_MUL, 16'hffff, 16'hffff, 16'hffff, 16'h7fff);
    send(CMD_DIV, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send(CMD_SUB, 16'd0, -16'sd5, 16'd0, 16'd9);
    send(CMD_COMPARE, 16'hffff, 16'h8000, 16'h5555, 16'haaaa);
    // Hold off until the unit has drained everything; the pending count is a
    // registered copy of the checker's queue size.
    s_tvalid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - 100) quiet = 1;
      send_random();
    end
    s_tvalid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    $display("Sent %0d items over all commands, with zero denominators and extremes;",
             sent);
    $display("checked %0d result items.", result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("rational_arithmetic_unit_tb passed");
    end else begin
      $display("rational_arithmetic_unit_tb failed");
    end
    $finish;
  end

endmodule
